/* sv/hsvr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvr_pkg: shared types and constants for the hsv to rgb converter
// Field widths, sector codes, queue sizing and the reciprocal used for the
// final constant division.
// ----------------------------------------------------------------------------
package hsvr_pkg;

    localparam int unsigned CHANNEL_BITS = 8;

    // input fields
    localparam int unsigned HUE_W  = 10;
    localparam int unsigned PCT_W  = 8;
    // wrapped fields
    localparam int unsigned WHUE_W = 9;
    localparam int unsigned WPCT_W = 7;
    localparam int unsigned REM_W  = 6;
    localparam int unsigned SEC_W  = 3;

    localparam int unsigned IN_TDATA_W  = ((HUE_W + 2 * PCT_W + 7) / 8) * 8;
    localparam int unsigned OUT_TDATA_W = ((3 * CHANNEL_BITS + 7) / 8) * 8;

    // sector codes, 60 degrees each
    localparam logic [SEC_W-1:0] SEC_R_Y = 3'd0;
    localparam logic [SEC_W-1:0] SEC_Y_G = 3'd1;
    localparam logic [SEC_W-1:0] SEC_G_C = 3'd2;
    localparam logic [SEC_W-1:0] SEC_C_B = 3'd3;
    localparam logic [SEC_W-1:0] SEC_B_M = 3'd4;
    localparam logic [SEC_W-1:0] SEC_M_R = 3'd5;

    // numerators are over 600000 = 60 * 100 * 100
    localparam int unsigned FACT_W   = 13;
    localparam int unsigned FULL     = 6000;
    localparam int unsigned NUM_W    = 20;
    localparam int unsigned DEN      = 600000;
    localparam int unsigned Y_W      = NUM_W + CHANNEL_BITS;
    localparam int unsigned SHIFT    = Y_W + 20;
    localparam int unsigned RECIP_W  = SHIFT - 18;
    localparam int unsigned PROD_W   = Y_W + RECIP_W;
    localparam logic [63:0] RECIP64  =
        ((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;

    typedef struct packed {
        logic [SEC_W-1:0]  sector;
        logic [REM_W-1:0]  rem;
        logic [WPCT_W-1:0] sat;
        logic [WPCT_W-1:0] val;
    } t_item;

endpackage

/* sv/hsvr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvr_front: input wrap and sector classification
// Wraps hue, saturation and value into range and splits hue into sector and
// remainder within the sector.
// ----------------------------------------------------------------------------
module hsvr_front import hsvr_pkg::*; (
    input  logic [HUE_W-1:0] i_hue,
    input  logic [PCT_W-1:0] i_sat,
    input  logic [PCT_W-1:0] i_val,
    output t_item            o_item
);

    logic [WHUE_W-1:0] w_hue;
    logic [WHUE_W-1:0] w_base;
    logic [SEC_W-1:0]  w_sector;

    always_comb begin
        if (i_hue > 10'd720) begin
            w_hue = WHUE_W'(i_hue - 10'd720);
        end else if (i_hue > 10'd360) begin
            w_hue = WHUE_W'(i_hue - 10'd360);
        end else begin
            w_hue = WHUE_W'(i_hue);
        end
    end

    // full circle folds back onto the first sector
    always_comb begin
        if (w_hue >= 9'd360) begin
            w_sector = SEC_R_Y;
            w_base   = 9'd360;
        end else if (w_hue >= 9'd300) begin
            w_sector = SEC_M_R;
            w_base   = 9'd300;
        end else if (w_hue >= 9'd240) begin
            w_sector = SEC_B_M;
            w_base   = 9'd240;
        end else if (w_hue >= 9'd180) begin
            w_sector = SEC_C_B;
            w_base   = 9'd180;
        end else if (w_hue >= 9'd120) begin
            w_sector = SEC_G_C;
            w_base   = 9'd120;
        end else if (w_hue >= 9'd60) begin
            w_sector = SEC_Y_G;
            w_base   = 9'd60;
        end else begin
            w_sector = SEC_R_Y;
            w_base   = 9'd0;
        end
    end

    always_comb begin
        o_item.sector = w_sector;
        o_item.rem    = REM_W'(w_hue - w_base);
        if (i_sat > 8'd200) begin
            o_item.sat = WPCT_W'(i_sat - 8'd200);
        end else if (i_sat > 8'd100) begin
            o_item.sat = WPCT_W'(i_sat - 8'd100);
        end else begin
            o_item.sat = WPCT_W'(i_sat);
        end
        if (i_val > 8'd200) begin
            o_item.val = WPCT_W'(i_val - 8'd200);
        end else if (i_val > 8'd100) begin
            o_item.val = WPCT_W'(i_val - 8'd100);
        end else begin
            o_item.val = WPCT_W'(i_val);
        end
    end

endmodule

/* sv/hsvr_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvr_fifo: short queue between classifier and arithmetic pipeline
// Register based, head word visible combinationally.
// ----------------------------------------------------------------------------
module hsvr_fifo import hsvr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_count;
    logic [FIFO_PTR_W:0]   n_count;

    assign o_full  = (r_count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_PTR_W + 1)'(FIFO_DEPTH))
        else $error("fifo count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty fifo with pointers apart");
`endif

endmodule

/* sv/hsvr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvr_back: four stage arithmetic pipeline
// Factors, p/q/t numerators with sector select, scale by full channel value,
// exact division by 600000 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module hsvr_back import hsvr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_item                     i_item,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [3*CHANNEL_BITS-1:0] o_rgb
);

    typedef struct packed {
        logic [SEC_W-1:0]  sector;
        logic [WPCT_W-1:0] val;
        logic [FACT_W-1:0] fp;
        logic [FACT_W-1:0] fq;
        logic [FACT_W-1:0] ft;
    } t_factors;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    t_factors          r_s1, n_s1;
    logic [NUM_W-1:0]  r_num2 [3];
    logic [NUM_W-1:0]  n_num2 [3];
    logic [Y_W-1:0]    r_y3   [3];
    logic [CHANNEL_BITS-1:0] r_chan4 [3];

    logic [FACT_W-1:0] w_rs;
    logic [NUM_W-1:0]  w_nv, w_np, w_nq, w_nt;
    logic [PROD_W-1:0] w_prod [3];

    // each stage moves when the one after it can take its word
    assign w_en4 = !r_v4 || i_ready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign o_pop = i_valid && w_en1;

    always_comb begin
        w_rs        = FACT_W'(i_item.rem) * FACT_W'(i_item.sat);
        n_s1.sector = i_item.sector;
        n_s1.val    = i_item.val;
        n_s1.fp     = FACT_W'(FULL) - FACT_W'(i_item.sat) * FACT_W'(60);
        n_s1.fq     = FACT_W'(FULL) - w_rs;
        // 6000 - (60 - r) s = 6000 - 60 s + r s
        n_s1.ft     = n_s1.fp + w_rs;
    end

    always_comb begin
        w_nv = NUM_W'(r_s1.val) * NUM_W'(FULL);
        w_np = NUM_W'(r_s1.val) * NUM_W'(r_s1.fp);
        w_nq = NUM_W'(r_s1.val) * NUM_W'(r_s1.fq);
        w_nt = NUM_W'(r_s1.val) * NUM_W'(r_s1.ft);
        unique case (r_s1.sector)
            SEC_R_Y: begin
                n_num2[0] = w_nv; n_num2[1] = w_nt; n_num2[2] = w_np;
            end
            SEC_Y_G: begin
                n_num2[0] = w_nq; n_num2[1] = w_nv; n_num2[2] = w_np;
            end
            SEC_G_C: begin
                n_num2[0] = w_np; n_num2[1] = w_nv; n_num2[2] = w_nt;
            end
            SEC_C_B: begin
                n_num2[0] = w_np; n_num2[1] = w_nq; n_num2[2] = w_nv;
            end
            SEC_B_M: begin
                n_num2[0] = w_nt; n_num2[1] = w_np; n_num2[2] = w_nv;
            end
            default: begin
                n_num2[0] = w_nv; n_num2[1] = w_np; n_num2[2] = w_nq;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_prod[i] = PROD_W'(r_y3[i]) * PROD_W'(RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1 <= n_s1;
        end
        for (int i = 0; i < 3; i++) begin
            if (w_en2) begin
                r_num2[i] <= n_num2[i];
            end
            if (w_en3) begin
                r_y3[i] <= Y_W'(r_num2[i]) * Y_W'({CHANNEL_BITS{1'b1}});
            end
            if (w_en4) begin
                r_chan4[i] <= w_prod[i][SHIFT +: CHANNEL_BITS];
            end
        end
    end

    assign o_valid = r_v4;
    assign o_rgb   = {r_chan4[2], r_chan4[1], r_chan4[0]};

`ifndef SYNTHESIS
    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_valid)
        else $error("pop from empty queue");

    a_refuse_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_pop) |-> (r_v1 && r_v2 && r_v3 && r_v4 && !i_ready))
        else $error("queue word refused with room in pipeline");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_v4 && !i_ready) |=> (r_v3 && r_v4))
        else $error("stalled pipeline lost a word");
`endif

endmodule

/* sv/hsv_to_rgb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_top: hsv to rgb pixel converter
// One pixel in, one pixel out; hue in degrees, saturation and value in
// percent, exact floor scaling to the channel width.
// ----------------------------------------------------------------------------
// usage
// slave stream takes one pixel word per handshake: tdata holds hue, then
// saturation, then value; out of range inputs wrap (hue by 360, the others
// by 100)
// master stream gives one rgb word per pixel, in input order
// a word goes through the queue and the pipeline registers to m_tvalid
// throughput: one pixel per cycle while m_tready is high, set by the four
// stage arithmetic pipeline which moves one word per stage per cycle
// a four word queue sits between the classifier and the pipeline
// when the receiver stalls the pipeline holds its words, the queue fills
// and s_tready drops once it holds four words
// reset clears the queue and every pipeline valid bit; words in flight
// are dropped
// ----------------------------------------------------------------------------
module hsv_to_rgb_top import hsvr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // hue_degrees[9:0], saturation_pct[17:10], value_pct[25:18], zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    t_item                     w_item_in;
    t_item                     w_item_head;
    logic                      w_full;
    logic                      w_push;
    logic                      w_head_valid;
    logic                      w_pop;
    logic [3*CHANNEL_BITS-1:0] w_rgb;

    assign o_s_tready = !w_full;
    assign w_push     = i_s_tvalid && !w_full;

    hsvr_front u_front (
        .i_hue  (i_s_tdata[HUE_W-1:0]),
        .i_sat  (i_s_tdata[HUE_W +: PCT_W]),
        .i_val  (i_s_tdata[HUE_W + PCT_W +: PCT_W]),
        .o_item (w_item_in)
    );

    hsvr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_item  (w_item_head)
    );

    hsvr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_head_valid),
        .i_item  (w_item_head),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_rgb   (w_rgb)
    );

    assign o_m_tdata = OUT_TDATA_W'(w_rgb);

endmodule
